### src/assert_macros.svh
// Assertion macros used by the port-level checker (dnc_checker.sv).
// Include guard keeps repeated inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipping cycles in reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal is low in the cycle after an edge that sees reset asserted.
`define ASSERT_RST_LOW(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) !rst_n |=> !(sig)) else $error(msg);

`endif

### src/dnc_pkg.sv
// Package for the double narrowing converter: mode codes and the
// conversion functions. No dependencies.
`default_nettype none
package dnc_pkg;

  localparam logic [1:0] ModeSigned   = 2'd0;
  localparam logic [1:0] ModeUnsigned = 2'd1;
  localparam logic [1:0] ModeSingle   = 2'd2;

  localparam int unsigned ModeWidth   = 2;
  localparam int unsigned DblWidth    = 64;
  localparam int unsigned ResultWidth = 32;

  // Truncate toward zero into int32 / uint32 with saturation.
  function automatic logic [31:0] conv_int(input logic [63:0] v, input logic is_signed);
    logic        neg;
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] sig;
    logic [5:0]  sh;
    logic [31:0] mag;
    neg = v[63];
    e   = v[62:52];
    m   = v[51:0];
    sig = {1'b1, m};
    sh  = 6'd52 - 6'(e - 11'd1023);
    mag = 32'(sig >> sh);
    if (is_signed) begin
      if (e == 11'h7FF && m != '0) conv_int = 32'h8000_0000;
      else if (e < 11'd1023) conv_int = '0;
      else if (e >= 11'd1054) conv_int = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else conv_int = neg ? (32'd0 - mag) : mag;
    end else begin
      if ((e == 11'h7FF && m != '0) || neg) conv_int = '0;
      else if (e < 11'd1023) conv_int = '0;
      else if (e >= 11'd1055) conv_int = 32'hFFFF_FFFF;
      else conv_int = mag;
    end
  endfunction

  // Round to nearest even into binary32, subnormals kept.
  // Rounding terms are 64 bits wide so the halfway point stays exact for
  // shifts past the significand width.
  function automatic logic [31:0] conv_single(input logic [63:0] v);
    logic        s;
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] sig;
    logic [12:0] fe;
    logic        normal;
    logic [12:0] shw;
    logic [5:0]  sh;
    logic [63:0] q;
    logic [63:0] rmask;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] qr;
    logic [12:0] fer;
    s   = v[63];
    e   = v[62:52];
    m   = v[51:0];
    sig = (e == '0) ? {1'b0, m} : {1'b1, m};
    fe  = ((e == '0) ? 13'd1 : {2'b0, e}) - 13'd896;
    normal = !fe[12] && fe != '0;
    shw = normal ? 13'd29 : 13'd30 - fe;
    sh  = (shw > 13'd60) ? 6'd60 : shw[5:0];
    q     = 64'(sig) >> sh;
    rmask = (64'd1 << sh) - 64'd1;
    rem   = 64'(sig) & rmask;
    half  = 64'd1 << (sh - 6'd1);
    qr    = ((rem > half) || (rem == half && q[0])) ? q + 64'd1 : q;
    fer   = fe;
    if (qr == 64'h100_0000) begin
      qr  = qr >> 1;
      fer = fe + 13'd1;
    end
    if (e == 11'h7FF) begin
      conv_single = (m == '0) ? {s, 31'h7F80_0000} : {s, 9'h1FF, m[50:29]};
    end else if (e == '0 && m == '0) begin
      conv_single = {s, 31'd0};
    end else if (!normal) begin
      conv_single = {s, qr[30:0]};
    end else if (fer >= 13'd255) begin
      conv_single = {s, 31'h7F80_0000};
    end else begin
      conv_single = {s, fer[7:0], qr[22:0]};
    end
  endfunction

endpackage
`default_nettype wire

### src/dnc_datapath.sv
// Combinational conversion datapath: mode select over the package functions.
// Depends on dnc_pkg.
`default_nettype none
module dnc_datapath
  import dnc_pkg::*;
(
  input  wire logic [ModeWidth-1:0]   req_type_i,
  input  wire logic [DblWidth-1:0]    value_bits_i,
  output logic      [ResultWidth-1:0] result_bits_o
);
  always_comb begin
    case (req_type_i)
      ModeSigned:   result_bits_o = conv_int(value_bits_i, 1'b1);
      ModeUnsigned: result_bits_o = conv_int(value_bits_i, 1'b0);
      ModeSingle:   result_bits_o = conv_single(value_bits_i);
      default:      result_bits_o = '0;
    endcase
  end
endmodule
`default_nettype wire

### src/double_narrowing_converter_core.sv
// Top level of the double narrowing converter: input register, conversion
// datapath, output register. Depends on dnc_pkg and dnc_datapath.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries a mode and a binary64
//    operand; output channel (out_valid_o / out_ready_i) carries one 32-bit
//    result per input transfer, in order.
//  - Each input passes the operand register, then the result register.
//  - Throughput: one item per cycle while the receiver takes results; each
//    stage advances whenever the stage after it is empty or is handing off
//    its item in the same cycle.
//  - Reset clears both stage valid bits; payloads are not reset.
//  - When the receiver stalls, hold the result and then the operand; the
//    input stops taking transfers only once both stages are full.
`default_nettype none
module double_narrowing_converter_core
  import dnc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [ModeWidth-1:0]   req_type_i,
  input  wire logic [DblWidth-1:0]    value_bits_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [ResultWidth-1:0] result_bits_o
);
  logic                   op_valid_q;
  logic [ModeWidth-1:0]   op_type_q;
  logic [DblWidth-1:0]    op_bits_q;
  logic                   res_valid_q;
  logic [ResultWidth-1:0] res_q;
  logic [ResultWidth-1:0] res_d;
  logic                   res_ready;

  // Result stage takes a new item when empty or draining this cycle.
  assign res_ready  = !res_valid_q || out_ready_i;
  assign in_ready_o = !op_valid_q || res_ready;

  dnc_datapath u_datapath (
    .req_type_i   (op_type_q),
    .value_bits_i (op_bits_q),
    .result_bits_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) op_valid_q <= in_valid_i;
      if (res_ready) res_valid_q <= op_valid_q;
    end
  end

  // Payload registers: load on advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_type_q <= req_type_i;
      op_bits_q <= value_bits_i;
    end
    if (res_ready && op_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign result_bits_o = res_q;
endmodule
`default_nettype wire

### src/dnc_checker.sv
// Port-level checker for the converter, bound to the top level.
// Depends on dnc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module dnc_checker
  import dnc_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [ResultWidth-1:0] result_bits_o
);
  `ASSERT_RST_LOW(a_rst_out, clk_i, rst_ni, out_valid_o, "out_valid during reset")
  `ASSERT_PROP(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_bits_o), "stalled result changed")
  `ASSERT_PROP(a_ready_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input blocked with empty output")
  // Quiet input that meets an empty output leaves nothing to emit.
  `ASSERT_PROP(a_no_spurious, clk_i, rst_ni, !(in_valid_i && in_ready_o) ##1 (!out_valid_o && !(in_valid_i && in_ready_o)) |=> !out_valid_o, "result without transfer")
endmodule

bind double_narrowing_converter_core dnc_checker u_dnc_checker (.*);
`default_nettype wire
